>>> sv/rpq_pkg.sv
// ----------------------------------------------------------------------------
// rpq_pkg: retro palette quantizer package
// Channel types, palette tables, mode codes and the L1 color distance.
// ----------------------------------------------------------------------------
package rpq_pkg;

  localparam int ChanW = 8;
  localparam int DistW = 10;
  localparam int IdxW  = 4;
  localparam int EgaN  = 16;
  localparam int CgaN  = 4;
  localparam int ModeW = 2;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } rgb_t;

  typedef enum logic [ModeW-1:0] {
    MODE_PASS = 2'd0,
    MODE_EGA  = 2'd1,
    MODE_CGA  = 2'd2
  } mode_e;

  localparam chan_t Lvl0 = 8'h00;
  localparam chan_t Lvl1 = 8'h55;
  localparam chan_t Lvl2 = 8'hAA;
  localparam chan_t Lvl3 = 8'hFF;

  function automatic rgb_t mk_rgb(chan_t r, chan_t g, chan_t b);
    rgb_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    return c;
  endfunction

  function automatic rgb_t ega_color(idx_t i);
    rgb_t c;
    case (i)
      4'd0:    c = mk_rgb(Lvl0, Lvl0, Lvl0);
      4'd1:    c = mk_rgb(Lvl0, Lvl0, Lvl2);
      4'd2:    c = mk_rgb(Lvl0, Lvl2, Lvl0);
      4'd3:    c = mk_rgb(Lvl0, Lvl2, Lvl2);
      4'd4:    c = mk_rgb(Lvl2, Lvl0, Lvl0);
      4'd5:    c = mk_rgb(Lvl2, Lvl0, Lvl2);
      4'd6:    c = mk_rgb(Lvl2, Lvl1, Lvl0);
      4'd7:    c = mk_rgb(Lvl2, Lvl2, Lvl2);
      4'd8:    c = mk_rgb(Lvl1, Lvl1, Lvl1);
      4'd9:    c = mk_rgb(Lvl1, Lvl1, Lvl3);
      4'd10:   c = mk_rgb(Lvl1, Lvl3, Lvl1);
      4'd11:   c = mk_rgb(Lvl1, Lvl3, Lvl3);
      4'd12:   c = mk_rgb(Lvl3, Lvl1, Lvl1);
      4'd13:   c = mk_rgb(Lvl3, Lvl1, Lvl3);
      4'd14:   c = mk_rgb(Lvl3, Lvl3, Lvl1);
      default: c = mk_rgb(Lvl3, Lvl3, Lvl3);
    endcase
    return c;
  endfunction

  function automatic rgb_t cga_color(idx_t i);
    rgb_t c;
    case (i[1:0])
      2'd0:    c = mk_rgb(Lvl0, Lvl0, Lvl0);
      2'd1:    c = mk_rgb(Lvl1, Lvl3, Lvl3);
      2'd2:    c = mk_rgb(Lvl3, Lvl1, Lvl3);
      default: c = mk_rgb(Lvl3, Lvl3, Lvl3);
    endcase
    return c;
  endfunction

  function automatic dist_t abs_diff(chan_t a, chan_t b);
    chan_t d;
    d = (a > b) ? (a - b) : (b - a);
    return {{(DistW-ChanW){1'b0}}, d};
  endfunction

  function automatic dist_t l1_dist(rgb_t a, rgb_t p);
    return abs_diff(a.red, p.red) + abs_diff(a.green, p.green) + abs_diff(a.blue, p.blue);
  endfunction

endpackage

>>> sv/retro_palette_quantizer.sv
// Registers: input register, then result register around the distance and minimum tree.
// Throughput: one pixel per cycle unless m_axis stalls; sixteen EGA and four CGA distances run in parallel.
// Reset: rst_ni is asynchronous, active low; clears both valid flags and sets
// palette_mode to pass-through.
// ----------------------------------------------------------------------------
// retro_palette_quantizer
// Maps an RGB pixel to the nearest EGA or CGA palette color by L1 distance,
// lowest index on a tie, or passes it through with index zero.
// ----------------------------------------------------------------------------
module retro_palette_quantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,     // palette_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata     // color_index, red_out, green_out, blue_out, pad
);
  import rpq_pkg::*;

  logic [ModeW-1:0] mode_q;
  logic             s1_valid_q;
  rgb_t             s1_pix_q;
  logic [ModeW-1:0] s1_mode_q;
  logic             out_valid_q;
  idx_t             out_idx_q;
  rgb_t             out_rgb_q;
  logic [ModeW-1:0] out_mode_q;

  logic out_ready;
  logic s1_ready;
  idx_t res_idx_d;
  rgb_t res_rgb_d;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PASS;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= s_axis_tvalid;
      if (out_ready) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid) begin
      s1_pix_q  <= s_axis_tdata;
      s1_mode_q <= mode_q;
    end
    if (out_ready && s1_valid_q) begin
      out_idx_q  <= res_idx_d;
      out_rgb_q  <= res_rgb_d;
      out_mode_q <= s1_mode_q;
    end
  end

  dist_t ed0 [EgaN];
  idx_t  ei0 [EgaN];
  dist_t ed1 [EgaN/2];
  idx_t  ei1 [EgaN/2];
  dist_t ed2 [EgaN/4];
  idx_t  ei2 [EgaN/4];
  dist_t ed3 [EgaN/8];
  idx_t  ei3 [EgaN/8];
  idx_t  ega_best;
  dist_t cd0 [CgaN];
  idx_t  ci0 [CgaN];
  dist_t cd1 [CgaN/2];
  idx_t  ci1 [CgaN/2];
  idx_t  cga_best;

  always_comb begin
    for (int k = 0; k < EgaN; k++) begin
      ei0[k] = idx_t'(k);
      ed0[k] = l1_dist(s1_pix_q, ega_color(idx_t'(k)));
    end
    for (int k = 0; k < EgaN/2; k++) begin
      if (ed0[2*k+1] < ed0[2*k]) begin
        ed1[k] = ed0[2*k+1];
        ei1[k] = ei0[2*k+1];
      end else begin
        ed1[k] = ed0[2*k];
        ei1[k] = ei0[2*k];
      end
    end
    for (int k = 0; k < EgaN/4; k++) begin
      if (ed1[2*k+1] < ed1[2*k]) begin
        ed2[k] = ed1[2*k+1];
        ei2[k] = ei1[2*k+1];
      end else begin
        ed2[k] = ed1[2*k];
        ei2[k] = ei1[2*k];
      end
    end
    for (int k = 0; k < EgaN/8; k++) begin
      if (ed2[2*k+1] < ed2[2*k]) begin
        ed3[k] = ed2[2*k+1];
        ei3[k] = ei2[2*k+1];
      end else begin
        ed3[k] = ed2[2*k];
        ei3[k] = ei2[2*k];
      end
    end
    ega_best = (ed3[1] < ed3[0]) ? ei3[1] : ei3[0];

    for (int k = 0; k < CgaN; k++) begin
      ci0[k] = idx_t'(k);
      cd0[k] = l1_dist(s1_pix_q, cga_color(idx_t'(k)));
    end
    for (int k = 0; k < CgaN/2; k++) begin
      if (cd0[2*k+1] < cd0[2*k]) begin
        cd1[k] = cd0[2*k+1];
        ci1[k] = ci0[2*k+1];
      end else begin
        cd1[k] = cd0[2*k];
        ci1[k] = ci0[2*k];
      end
    end
    cga_best = (cd1[1] < cd1[0]) ? ci1[1] : ci1[0];

    unique case (s1_mode_q)
      MODE_PASS: begin
        res_idx_d = '0;
        res_rgb_d = s1_pix_q;
      end
      MODE_EGA: begin
        res_idx_d = ega_best;
        res_rgb_d = ega_color(ega_best);
      end
      default: begin
        res_idx_d = cga_best;
        res_rgb_d = cga_color(cga_best);
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_rgb_q, out_idx_q};

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_ready |=> s1_valid_q)
    else $error("stage one word dropped while output stalled");

  a_pass_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_mode_q == MODE_PASS |-> out_idx_q == '0)
    else $error("nonzero index in pass-through");

  a_cga_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_mode_q != MODE_PASS && out_mode_q != MODE_EGA
      |-> out_idx_q[IdxW-1:2] == '0)
    else $error("CGA index out of range");

endmodule
